// ===== src/spd_pkg.sv =====
// ---------------------------------------------------------------------------
// spd_pkg
// shared types, constants and codes of the serial packet deframer
// ---------------------------------------------------------------------------
package spd_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// input actions
	localparam logic [1:0] ACT_RX_BYTE = 2'd0;
	localparam logic [1:0] ACT_POLL    = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	// internal command codes
	localparam logic [1:0] OP_RX_BYTE = 2'd0;
	localparam logic [1:0] OP_POLL    = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// register indexes (paddr[2])
	localparam logic REG_FRAME_MODE  = 1'b0;
	localparam logic REG_PAYLOAD_LEN = 1'b1;

	localparam logic [6:0] PAYLOAD_LEN_RST = 7'd8;

	// framing characters
	localparam logic [7:0] BYTE_SOF = 8'hFF;
	localparam logic [7:0] BYTE_EOF = 8'hFE;
	localparam logic [7:0] CHAR_AT  = 8'h40;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [5:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       frame_ready;
		logic [7:0] read_data;
		logic [6:0] frame_length;
		logic [1:0] receiver_phase;
	} out_item_t;

	typedef struct packed {
		logic is_sof;
		logic is_eof;
		logic is_at;
		logic is_cr;
		logic is_lf;
	} byte_class_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        data;
		byte_class_t       cls;
		logic              rd_ok;
		logic [ADDR_W-1:0] rd_addr;
	} cmd_t;

	typedef struct packed {
		logic frame_mode;
		logic [6:0] payload_length;
	} cfg_t;

endpackage

// ===== src/spd_front.sv =====
// ---------------------------------------------------------------------------
// spd_front
// accepts input transactions, decodes and classifies them into commands
// and holds them in a two-entry queue for the back end
// ---------------------------------------------------------------------------
module spd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spd_pkg::in_item_t push_data,
	output logic              full,
	output logic              cmd_valid,
	output spd_pkg::cmd_t     cmd,
	input  logic              cmd_take
);
	import spd_pkg::*;

	cmd_t       cmd_in;
	cmd_t       mq_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;

	always_comb begin
		unique case (push_data.action)
			ACT_RX_BYTE: cmd_in.op = OP_RX_BYTE;
			ACT_POLL:    cmd_in.op = OP_POLL;
			ACT_READ:    cmd_in.op = OP_READ;
			default:     cmd_in.op = OP_NONE;
		endcase
		cmd_in.data       = push_data.rx_byte;
		cmd_in.cls.is_sof = (push_data.rx_byte == BYTE_SOF);
		cmd_in.cls.is_eof = (push_data.rx_byte == BYTE_EOF);
		cmd_in.cls.is_at  = (push_data.rx_byte == CHAR_AT);
		cmd_in.cls.is_cr  = (push_data.rx_byte == CHAR_CR);
		cmd_in.cls.is_lf  = (push_data.rx_byte == CHAR_LF);
		cmd_in.rd_ok      = (32'(push_data.read_index) < STORE_DEPTH);
		cmd_in.rd_addr    = ADDR_W'(push_data.read_index);
	end

	assign full      = (cnt_q == 2'd2);
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mq_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mq_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (cmd_take) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_take};
		end
	end

endmodule

// ===== src/spd_back.sv =====
// ---------------------------------------------------------------------------
// spd_back
// executes commands: framing state machine, payload store, result stage
// ---------------------------------------------------------------------------
module spd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spd_pkg::cfg_t                 cfg,
	input  logic                          cmd_valid,
	input  spd_pkg::cmd_t                 cmd,
	output logic                          cmd_take,
	input  logic [spd_pkg::OQ_CNT_W-1:0]  oq_level,
	output logic                          res_valid,
	output spd_pkg::out_item_t            res
);
	import spd_pkg::*;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_COLLECT = 2'd1;
	localparam logic [1:0] PH_AWAIT   = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ready_q, ready_d;
	logic [CNT_W-1:0] len_eff;
	logic             wr_en;
	logic [7:0]       wr_data;
	logic             rd_en;

	logic [7:0]             mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] mvalid_q;

	logic             s2_valid_q;
	logic             flag_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [1:0]       phase_s2;
	logic             rd_s2;
	logic             rvalid_s2;
	logic [7:0]       rdata_s2;

	// room for this result and the one already in the result stage
	assign cmd_take = cmd_valid &&
		((32'(oq_level) + 32'(s2_valid_q)) < OQ_DEPTH);

	always_comb begin
		if (cfg.payload_length == 7'd0) begin
			len_eff = CNT_W'(1);
		end else if (32'(cfg.payload_length) > STORE_DEPTH) begin
			len_eff = CNT_W'(STORE_DEPTH);
		end else begin
			len_eff = CNT_W'(cfg.payload_length);
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		ready_d = ready_q;
		wr_en   = 1'b0;
		wr_data = cmd.data;
		rd_en   = 1'b0;
		if (cmd_take) begin
			case (cmd.op)
				OP_RX_BYTE: begin
					if (!cfg.frame_mode) begin
						unique case (phase_q)
							PH_COLLECT: begin
								if (32'(cnt_q) < STORE_DEPTH) begin
									wr_en = 1'b1;
									cnt_d = cnt_q + CNT_W'(1);
								end
								if (cnt_d >= len_eff || 32'(cnt_d) >= STORE_DEPTH) begin
									phase_d = PH_AWAIT;
								end
							end
							PH_AWAIT: begin
								if (cmd.cls.is_eof) begin
									phase_d = PH_HUNT;
									ready_d = 1'b1;
								end
							end
							default: begin
								if (cmd.cls.is_sof) begin
									phase_d = PH_COLLECT;
									cnt_d   = '0;
								end
							end
						endcase
					end else begin
						unique case (phase_q)
							PH_COLLECT: begin
								if (cmd.cls.is_cr) begin
									phase_d = PH_AWAIT;
								end else if ((32'(cnt_q) + 1) < STORE_DEPTH) begin
									wr_en = 1'b1;
									cnt_d = cnt_q + CNT_W'(1);
								end
							end
							PH_AWAIT: begin
								if (cmd.cls.is_lf) begin
									phase_d = PH_HUNT;
									ready_d = 1'b1;
									wr_data = CHAR_NUL;
									wr_en   = (32'(cnt_q) < STORE_DEPTH);
								end
							end
							default: begin
								if (cmd.cls.is_at && !ready_q) begin
									phase_d = PH_COLLECT;
									cnt_d   = '0;
								end
							end
						endcase
					end
				end
				OP_POLL: ready_d = 1'b0;
				OP_READ: rd_en = cmd.rd_ok;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[ADDR_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_s2 <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			cnt_q      <= '0;
			ready_q    <= 1'b0;
			mvalid_q   <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			ready_q    <= ready_d;
			s2_valid_q <= cmd_take;
			if (wr_en) begin
				mvalid_q[cnt_q[ADDR_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			flag_s2   <= ready_q;
			cnt_s2    <= cnt_d;
			phase_s2  <= phase_d;
			rd_s2     <= rd_en;
			rvalid_s2 <= mvalid_q[cmd.rd_addr];
		end
	end

	assign res_valid              = s2_valid_q;
	assign res.frame_ready        = flag_s2;
	assign res.read_data          = (rd_s2 && rvalid_s2) ? rdata_s2 : 8'h00;
	assign res.frame_length       = (32'(cnt_s2) > 127) ? 7'd127 : 7'(cnt_s2);
	assign res.receiver_phase     = phase_s2;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= STORE_DEPTH)
		else $error("byte count beyond store depth");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && phase_q == PH_HUNT && phase_d == PH_COLLECT) |=> (cnt_q == '0))
		else $error("frame opened with nonzero count");

	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(cmd_take && cmd.op == OP_RX_BYTE && phase_q == PH_AWAIT))
		else $error("ready flag set outside an end marker");

endmodule

// ===== src/spd_outq.sv =====
// ---------------------------------------------------------------------------
// spd_outq
// result queue, decouples the back end from the consumer
// ---------------------------------------------------------------------------
module spd_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  spd_pkg::out_item_t           wr_data,
	input  logic                         pop,
	output logic                         empty,
	output spd_pkg::out_item_t           pop_data,
	output logic [spd_pkg::OQ_CNT_W-1:0] level
);
	import spd_pkg::*;

	out_item_t           q_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wptr_q;
	logic [OQ_PTR_W-1:0] rptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                do_pop;

	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign pop_data = q_q[rptr_q];
	assign level    = cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + OQ_PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + OQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + OQ_CNT_W'(wr) - OQ_CNT_W'(do_pop);
		end
	end

endmodule

// ===== src/serial_packet_deframer_top.sv =====
// ---------------------------------------------------------------------------
// serial_packet_deframer_top
// pulls binary (0xFF..0xFE) or text ('@'..CR LF) frames out of a serial
// byte stream into a 64-byte payload store, with poll and read actions
// ---------------------------------------------------------------------------
//  channel   handshake         payload      notes
//  input     push / full       push_data    one action per transaction
//  result    pop / empty       pop_data     one result per input transaction
//  config    apb (psel..)      pwdata       frame_mode @0x0, payload_length @0x4
//
//  one input transaction per cycle sustained while results are popped; a result
//  reaches the result ports through the front queue, the execute stage with
//  the store read register, and the result queue
//  the framing state update and one store access happen in the same cycle
//  reset clears state and store valid bits at once, no clearing pass
//  a stalled result side fills the result queue, then the front queue, then
//  raises full; neither side loses or repeats a transaction
// ---------------------------------------------------------------------------
module serial_packet_deframer_top (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	input  spd_pkg::in_item_t  push_data,
	output logic               full,
	// result queue side
	input  logic               pop,
	output logic               empty,
	output spd_pkg::out_item_t pop_data,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import spd_pkg::*;

	cfg_t                cfg_q;
	logic                cfg_wr;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_take;
	logic [OQ_CNT_W-1:0] oq_level;
	logic                res_valid;
	out_item_t           res;

	// config registers, written on the apb access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_mode     <= 1'b0;
			cfg_q.payload_length <= PAYLOAD_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_MODE:  cfg_q.frame_mode     <= pwdata[0];
				REG_PAYLOAD_LEN: cfg_q.payload_length <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_FRAME_MODE:  prdata = {31'd0, cfg_q.frame_mode};
			REG_PAYLOAD_LEN: prdata = {25'd0, cfg_q.payload_length};
			default:         prdata = '0;
		endcase
	end

	// front: decode, classify, queue
	spd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// back: framing state, payload store, result stage
	spd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.oq_level  (oq_level),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue toward the consumer
	spd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_valid),
		.wr_data  (res),
		.pop      (pop),
		.empty    (empty),
		.pop_data (pop_data),
		.level    (oq_level)
	);

endmodule
